// ===== rtl/core/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP receive package
// Word types for the packet and result channels and the protocol constants
// shared by the ARP receive cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HW    = 2'd1;
  localparam logic [1:0] ST_BAD_PROTO = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Configuration register map, decoded on address bit 3.
  localparam int          PADDR_W        = 4;
  localparam logic        REG_STATION_IP = 1'b0;

  localparam logic [31:0] STATION_IP_RST  = 32'h0200000a;
  localparam logic [47:0] STATION_MAC_RST = 48'h00504378899a;

  typedef struct packed {
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [15:0] operation;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reply_valid;
    logic [15:0] reply_operation;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic        entry_refreshed;
    logic        entry_inserted;
  } arp_rsp_t;

  // One cache entry as held in memory.
  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } arp_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/arp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/arp_receive_cache_and_reply.sv =====
// ----------------------------------------------------------------------------
// ARP receive cache and reply
// Checks received ARP packets, keeps an IP-to-MAC cache and forms replies.
// ----------------------------------------------------------------------------
// Each packet word yields exactly one result word. After acceptance a
// rejected packet goes from CHECK straight to DONE, and with an empty cache
// from CHECK to DECIDE and DONE; otherwise the cache lives in one
// single-port-read memory and is searched in SEARCH one entry per cycle up
// to the number of entries in use, then DECIDE writes the refreshed or
// inserted entry. A new packet is taken once the previous result has moved
// to the output register, even if that result has not yet been taken.
// Entries are never removed, so the cache is always filled from entry zero
// upwards and a fill count stands for the valid bits; no clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_receive_cache_and_reply
  import arp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire arp_req_t           req,

  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output arp_rsp_t                rsp,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_DECIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t       state, state_next;
  arp_req_t     item;
  arp_rsp_t     res, res_next;
  logic [31:0]  station_ip;
  logic [47:0]  station_mac;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] hit_idx, hit_idx_next;
  logic         found, found_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  arp_entry_t       ram_wdata;
  arp_entry_t       ram_rdata;

  logic cfg_write;
  logic to_us;
  logic want_reply;
  logic last_entry;
  logic out_free;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[3] == REG_STATION_IP) ? {32'b0, station_ip}
                                                  : {16'b0, station_mac};

  always_ff @(posedge clk) begin
    if (rst) begin
      station_ip  <= STATION_IP_RST;
      station_mac <= STATION_MAC_RST;
    end else if (cfg_write) begin
      if (paddr[3] == REG_STATION_IP) begin
        station_ip <= pwdata[31:0];
      end else begin
        station_mac <= pwdata[47:0];
      end
    end
  end

  arp_ram #(
    .WIDTH  ($bits(arp_entry_t)),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready  = (state == S_IDLE);
  assign out_free   = !rsp_valid || rsp_ready;
  assign to_us      = (item.target_ip == station_ip);
  assign want_reply = to_us && (item.operation == OP_REQUEST);
  assign last_entry = ({1'b0, idx} + CNT_W'(1)) == count;

  // A refresh rewrites the matching entry with the same IP, so both cases
  // write the sender pair as a whole word.
  assign ram_wdata = '{mac: item.sender_mac, ip: item.sender_ip};

  always_comb begin
    state_next   = state;
    res_next     = res;
    count_next   = count;
    idx_next     = idx;
    hit_idx_next = hit_idx;
    found_next   = found;
    ram_we       = 1'b0;
    ram_waddr    = hit_idx;
    ram_raddr    = idx;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        res_next   = '0;
        found_next = 1'b0;
        idx_next   = '0;
        ram_raddr  = '0;
        if (item.hardware_type != HW_ETHERNET) begin
          res_next.status = ST_BAD_HW;
          state_next      = S_DONE;
        end else if (item.protocol_type != PROTO_IPV4) begin
          res_next.status = ST_BAD_PROTO;
          state_next      = S_DONE;
        end else if (count == '0) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // Read data here belongs to the entry at idx, whose read was issued in the previous cycle.
        if (ram_rdata.ip == item.sender_ip) begin
          found_next   = 1'b1;
          hit_idx_next = idx;
          state_next   = S_DECIDE;
        end else if (last_entry) begin
          state_next = S_DECIDE;
        end else begin
          idx_next  = idx + IDX_W'(1);
          ram_raddr = idx + IDX_W'(1);
        end
      end

      S_DECIDE: begin
        res_next = '0;
        if (found) begin
          ram_we                   = 1'b1;
          ram_waddr                = hit_idx;
          res_next.entry_refreshed = 1'b1;
          res_next.reply_valid     = want_reply;
        end else if (to_us) begin
          if (count == FULL_COUNT) begin
            res_next.status = ST_FULL;
          end else begin
            ram_we                  = 1'b1;
            ram_waddr               = count[IDX_W-1:0];
            count_next              = count + CNT_W'(1);
            res_next.entry_inserted = 1'b1;
            res_next.reply_valid    = want_reply;
          end
        end
        if (res_next.reply_valid) begin
          res_next.reply_operation  = OP_REPLY;
          res_next.reply_sender_mac = station_mac;
          res_next.reply_sender_ip  = item.target_ip;
          res_next.reply_target_mac = item.sender_mac;
          res_next.reply_target_ip  = item.sender_ip;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
    res     <= res_next;
    idx     <= idx_next;
    hit_idx <= hit_idx_next;
    found   <= found_next;
  end

endmodule

`default_nettype wire

// ===== dv/arp_receive_cache_and_reply_tb.sv =====
// ----------------------------------------------------------------------------
// ARP receive cache and reply testbench
// Drives ARP packet words into the block and checks every result word
// against a cycle-free predictor or, for some directed rows, against a
// hand-written result. The predictor keeps its own IP-to-MAC cache and
// station registers. A short table of directed packets covers the rejects,
// insertion, refresh, a full cache and replies. Random phases follow, each
// under a different station setting and mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_receive_cache_and_reply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_pkg::*;

  localparam int TABLE_ENTRIES   = 16;
  localparam int ITEMS_PER_PHASE = 410;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = TABLE_ENTRIES + 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [PADDR_W-1:0] ADDR_STATION_IP  = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_STATION_MAC = 4'h8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    arp_req_t pkt;
    bit       typed;
    arp_rsp_t rsp;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  arp_req_t           req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  arp_rsp_t           rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  // Travels alongside req: the hand-written result for a directed row.
  logic               row_typed = 1'b0;
  arp_rsp_t           row_typed_rsp = '0;

  // Predictor state.
  bit                 cache_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [31:0]        cache_ip    [TABLE_ENTRIES] = '{default: '0};
  logic [47:0]        cache_mac   [TABLE_ENTRIES] = '{default: '0};
  logic [31:0]        station_ip_q  = STATION_IP_RST;
  logic [47:0]        station_mac_q = STATION_MAC_RST;

  arp_rsp_t           pending_results [$];
  arp_rsp_t           predicted_word;
  stim_row_t          directed_rows [$];
  idle_mode_t         idle_mode = IDLE_NONE;
  bit                 hold_request = 1'b0;
  int                 mismatches = 0;
  int                 cycle_count = 0;

  arp_receive_cache_and_reply #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the result word of one packet and updates the cache copy.
  function automatic arp_rsp_t resolve_arp(input arp_req_t p);
    arp_rsp_t r;
    int       hit;
    int       slot;
    int       i;
    r    = '0;
    hit  = -1;
    slot = -1;
    if (p.hardware_type != HW_ETHERNET) begin
      r.status = ST_BAD_HW;
      return r;
    end
    if (p.protocol_type != PROTO_IPV4) begin
      r.status = ST_BAD_PROTO;
      return r;
    end
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && cache_valid[i] && cache_ip[i] == p.sender_ip) hit = i;
    end
    if (hit >= 0) begin
      cache_mac[hit]    = p.sender_mac;
      r.entry_refreshed = 1'b1;
    end
    if (p.target_ip == station_ip_q) begin
      if (hit < 0) begin
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot < 0 && !cache_valid[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_FULL;
          return r;
        end
        cache_valid[slot] = 1'b1;
        cache_ip[slot]    = p.sender_ip;
        cache_mac[slot]   = p.sender_mac;
        r.entry_inserted  = 1'b1;
      end
      if (p.operation == OP_REQUEST) begin
        r.reply_valid      = 1'b1;
        r.reply_operation  = OP_REPLY;
        r.reply_sender_mac = station_mac_q;
        r.reply_sender_ip  = p.target_ip;
        r.reply_target_mac = p.sender_mac;
        r.reply_target_ip  = p.sender_ip;
      end
    end
    r.status = ST_OK;
    return r;
  endfunction

  function automatic string fmt_rsp(input arp_rsp_t r);
    return $sformatf({"status=%0d reply=%0b op=%h smac=%h sip=%h tmac=%h tip=%h",
                      " refreshed=%0b inserted=%0b"},
                     r.status, r.reply_valid, r.reply_operation, r.reply_sender_mac,
                     r.reply_sender_ip, r.reply_target_mac, r.reply_target_ip,
                     r.entry_refreshed, r.entry_inserted);
  endfunction

  task automatic compare_result(input arp_rsp_t want, input arp_rsp_t got);
    bit bad;
    bad = (want.status !== got.status) || (want.reply_valid !== got.reply_valid) ||
          (want.reply_operation !== got.reply_operation) ||
          (want.reply_sender_mac !== got.reply_sender_mac) ||
          (want.reply_sender_ip !== got.reply_sender_ip) ||
          (want.reply_target_mac !== got.reply_target_mac) ||
          (want.reply_target_ip !== got.reply_target_ip) ||
          (want.entry_refreshed !== got.entry_refreshed) ||
          (want.entry_inserted !== got.entry_inserted);
    if (bad) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("result mismatch at cycle %0d", cycle_count);
        $display("  expected %s", fmt_rsp(want));
        $display("  actual   %s", fmt_rsp(got));
      end
    end
  endtask

  // Outputs are checked before the newly accepted packet is predicted; a
  // result can never leave in the cycle its packet was taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result word at cycle %0d: %s", cycle_count, fmt_rsp(rsp));
          end
        end else begin
          compare_result(pending_results.pop_front(), rsp);
        end
      end
      if (req_valid && req_ready) begin
        predicted_word = resolve_arp(req);
        pending_results.push_back(row_typed ? row_typed_rsp : predicted_word);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_receive_cache_and_reply_tb: FAIL");
      $finish;
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:   return $urandom_range(0, 99) < 9;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:     return $urandom_range(0, 99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver side. A long hold-off lets the block fill up and push back.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= !receiver_stalls();
    end
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic arp_req_t mk_pkt(input logic [15:0] hw, input logic [15:0] proto,
                                      input logic [15:0] op, input logic [47:0] smac,
                                      input logic [31:0] sip, input logic [31:0] tip);
    arp_req_t p;
    p.hardware_type = hw;
    p.protocol_type = proto;
    p.operation     = op;
    p.sender_mac    = smac;
    p.sender_ip     = sip;
    p.target_ip     = tip;
    return p;
  endfunction

  function automatic arp_rsp_t error_rsp(input logic [1:0] status);
    arp_rsp_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

  task automatic add_row(input arp_req_t pkt, input bit typed, input arp_rsp_t r);
    stim_row_t row;
    row.pkt   = pkt;
    row.typed = typed;
    row.rsp   = r;
    directed_rows.push_back(row);
  endtask

  // Mostly well-formed packets: the sender IP often names a cached entry
  // and the target is often this station.
  function automatic arp_req_t random_packet();
    arp_req_t p;
    int       pick;
    p.hardware_type = ($urandom_range(0, 15) == 0) ? 16'($urandom) : HW_ETHERNET;
    p.protocol_type = ($urandom_range(0, 15) == 0) ? 16'($urandom) : PROTO_IPV4;
    pick = $urandom_range(0, 3);
    p.operation  = (pick < 2) ? OP_REQUEST : (pick == 2) ? OP_REPLY : 16'($urandom);
    p.sender_mac = rand_mac();
    pick = $urandom_range(0, TABLE_ENTRIES - 1);
    p.sender_ip  = ($urandom_range(0, 2) != 0 && cache_valid[pick]) ? cache_ip[pick] : $urandom;
    p.target_ip  = $urandom_range(0, 1) ? station_ip_q : $urandom;
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_packet(input arp_req_t p, input bit typed, input arp_rsp_t r);
    while (sender_idles()) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    req           <= p;
    row_typed     <= typed;
    row_typed_rsp <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Returns on a falling edge, once the bus has gone idle again.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_STATION_IP) station_ip_q = data[31:0];
    else station_mac_q = data[47:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // The sender stops until every outstanding word has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_station(input logic [31:0] ip, input logic [47:0] mac);
    apb_write(ADDR_STATION_IP, {$urandom, ip});
    apb_write(ADDR_STATION_MAC, {16'($urandom), mac});
  endtask

  initial begin
    arp_rsp_t first_reply;
    int       k;
    int       ph;
    logic [15:0] fill_op;

    add_row(mk_pkt(16'hffff, PROTO_IPV4, OP_REQUEST, rand_mac(), $urandom, STATION_IP_RST),
            1'b1, error_rsp(ST_BAD_HW));
    add_row(mk_pkt(16'h0000, PROTO_IPV4, OP_REQUEST, rand_mac(), $urandom, STATION_IP_RST),
            1'b1, error_rsp(ST_BAD_HW));
    add_row(mk_pkt(HW_ETHERNET, 16'hffff, OP_REQUEST, rand_mac(), $urandom, STATION_IP_RST),
            1'b1, error_rsp(ST_BAD_PROTO));
    add_row(mk_pkt(HW_ETHERNET, 16'h0000, OP_REQUEST, rand_mac(), $urandom, STATION_IP_RST),
            1'b1, error_rsp(ST_BAD_PROTO));
    // A request for this station from an unknown sender lands in entry zero.
    first_reply = '{status: ST_OK, reply_valid: 1'b1, reply_operation: OP_REPLY,
                    reply_sender_mac: STATION_MAC_RST, reply_sender_ip: STATION_IP_RST,
                    reply_target_mac: '1, reply_target_ip: '1,
                    entry_refreshed: 1'b0, entry_inserted: 1'b1};
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, '1, STATION_IP_RST),
            1'b1, first_reply);
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '0, '1, STATION_IP_RST), 1'b0, '0);
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, '0, 32'hffff_ffff), 1'b0, '0);
    // A known sender is refreshed even when the packet is not for us.
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, 16'hffff, rand_mac(), '1, '0), 1'b0, '0);
    for (k = 0; k < TABLE_ENTRIES - 1; k++) begin
      fill_op = (k % 3 == 0) ? OP_REQUEST : (k % 3 == 1) ? OP_REPLY : 16'hffff;
      add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, fill_op, rand_mac(), 32'(k), STATION_IP_RST),
              1'b0, '0);
    end
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand_mac(), 32'hc0a8_0001,
                   STATION_IP_RST), 1'b1, error_rsp(ST_FULL));
    // With the cache full, a hit in the last entry still refreshes and replies.
    add_row(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand_mac(), 32'(TABLE_ENTRIES - 2),
                   STATION_IP_RST), 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      push_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].rsp);
    end
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_station(32'hffff_ffff, 48'h0);
          idle_mode = IDLE_NONE;
          hold_request = 1'b1;
        end
        1: begin
          set_station(32'h0, 48'hffff_ffff_ffff);
          idle_mode = IDLE_SENDER;
        end
        2: begin
          set_station($urandom, rand_mac());
          idle_mode = IDLE_RECEIVER;
        end
        default: begin
          set_station(STATION_IP_RST, STATION_MAC_RST);
          idle_mode = IDLE_BOTH;
        end
      endcase
      repeat (ITEMS_PER_PHASE) push_packet(random_packet(), 1'b0, '0);
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("arp_receive_cache_and_reply_tb: PASS");
    end else begin
      $display("arp_receive_cache_and_reply_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
